>>> sv/eba_pkg.sv
// eba_pkg: shared constants, codes and structs of the event bid arbiter
// no dependencies; imported by every module of the block
package eba_pkg;

   localparam int THREADS    = 8;
   localparam int EVENT_BITS = 32;
   localparam int TID_W      = 3;
   localparam int CNT_W      = 4;
   localparam int EV_IDX_W   = 5;
   localparam int POP_W      = 6;
   localparam int LFSR_W     = 16;
   localparam int MOD_STEPS  = 16;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [CNT_W-1:0]  MAX_LIMIT = 4'd8;

   localparam logic       OP_BID   = 1'b0;
   localparam logic       OP_OFFER = 1'b1;

   localparam logic [1:0] KIND_NOTIFY   = 2'd0;
   localparam logic [1:0] KIND_EXTERNAL = 2'd1;
   localparam logic [1:0] KIND_FINISHED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_THREADS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RANDOM_SEED    = 1'b1;

   typedef struct packed {
      logic                  bid_we;
      logic [TID_W-1:0]      bid_tid;
      logic [EVENT_BITS-1:0] bid_req;
      logic [EVENT_BITS-1:0] bid_wait;
      logic [EVENT_BITS-1:0] bid_block;
      logic                  bid_finished;
      logic                  clr_we;
      logic [TID_W-1:0]      clr_tid;
      logic [EVENT_BITS-1:0] clr_mask;
   } store_wr_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0] req;
      logic [EVENT_BITS-1:0] waits;
      logic [EVENT_BITS-1:0] block;
      logic                  done;
   } store_rd_type;

   typedef struct packed {
      logic              start;
      logic [LFSR_W-1:0] dividend;
      logic [POP_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [POP_W-1:0] remainder;
   } mod_rsp_type;

endpackage

>>> sv/eba_mod_unit.sv
// eba_mod_unit: iterative restoring modulo, one quotient bit per cycle
// depends on eba_pkg
module eba_mod_unit
   import eba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LFSR_W-1:0] dvd_ff, dvd_in;
   logic [POP_W-1:0]  dvs_ff, dvs_in;
   logic [POP_W:0]    rem_ff, rem_in;
   logic [POP_W:0]    shifted;

   assign shifted = {rem_ff[POP_W-1:0], dvd_ff[LFSR_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = mod_req.dividend;
         dvs_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[LFSR_W-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
         end else begin
            rem_in = shifted;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff[POP_W-1:0];

endmodule

>>> sv/eba_bid_store.sv
// eba_bid_store: per-thread bid table with done flags, one read index
// depends on eba_pkg
module eba_bid_store
   import eba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  store_wr_type     wr,
   input  logic [TID_W-1:0] rd_tid,
   output store_rd_type     rd
);

   logic [EVENT_BITS-1:0] req_ff   [THREADS];
   logic [EVENT_BITS-1:0] wait_ff  [THREADS];
   logic [EVENT_BITS-1:0] block_ff [THREADS];
   logic [THREADS-1:0]    valid_ff, valid_in;
   logic [THREADS-1:0]    done_ff, done_in;

   always_comb begin
      valid_in = valid_ff;
      done_in  = done_ff;
      if (wr.bid_we) begin
         valid_in[wr.bid_tid] = 1'b1;
         if (wr.bid_finished) begin
            done_in[wr.bid_tid] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         done_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
      if (wr.bid_we) begin
         req_ff[wr.bid_tid]   <= wr.bid_req;
         wait_ff[wr.bid_tid]  <= wr.bid_wait;
         block_ff[wr.bid_tid] <= wr.bid_block;
      end else if (wr.clr_we) begin
         wait_ff[wr.clr_tid] <= wait_ff[wr.clr_tid] & ~wr.clr_mask;
      end
   end

   // entries never written read as zero
   always_comb begin
      rd.done = done_ff[rd_tid];
      if (valid_ff[rd_tid]) begin
         rd.req   = req_ff[rd_tid];
         rd.waits = wait_ff[rd_tid];
         rd.block = block_ff[rd_tid];
      end else begin
         rd.req   = '0;
         rd.waits = '0;
         rd.block = '0;
      end
   end

endmodule

>>> sv/event_bid_arbiter.sv
// event_bid_arbiter: a bid that does not close the round is stored and the arbiter stays idle.
// after the closing bid a decision over N active threads runs scan, find, bit count, modulo,
// select, mark and emit, and waits out any result stalls; with nothing allowed it answers after find.
// an external offer, taken only while one is awaited, runs scan, find, select, mark and emit;
// one transaction at a time, req_ready low while the shared bit scan and modulo unit work.
// synchronous reset: no bids, 8 threads, seed 1.
module event_bid_arbiter
   import eba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [TID_W-1:0]      req_thread_id,
   input  logic [EVENT_BITS-1:0] req_req_mask,
   input  logic [EVENT_BITS-1:0] req_wait_mask,
   input  logic [EVENT_BITS-1:0] req_block_mask,
   input  logic [EVENT_BITS-1:0] req_cancel_mask,
   input  logic                  req_thread_finished,
   input  logic [EVENT_BITS-1:0] req_external_events,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [TID_W-1:0]      rsp_notify_thread,
   output logic [EVENT_BITS-1:0] rsp_chosen_event,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SCAN   = 9'b000000010,
      ST_FIND   = 9'b000000100,
      ST_COUNT  = 9'b000001000,
      ST_DIVIDE = 9'b000010000,
      ST_SELECT = 9'b000100000,
      ST_MARK   = 9'b001000000,
      ST_EMIT   = 9'b010000000,
      ST_SINGLE = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      pending_ff, pending_in;
   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in;
   logic                  awaiting_ff, awaiting_in;
   logic                  offer_ff, offer_in;
   logic [EVENT_BITS-1:0] ext_ff, ext_in;
   logic [EVENT_BITS-1:0] req_or_ff, req_or_in;
   logic [EVENT_BITS-1:0] wait_or_ff, wait_or_in;
   logic [EVENT_BITS-1:0] blk_or_ff, blk_or_in;
   logic [EVENT_BITS-1:0] cand_ff, cand_in;
   logic [EVENT_BITS-1:0] chosen_ff, chosen_in;
   logic [TID_W-1:0]      idx_ff, idx_in;
   logic [EV_IDX_W-1:0]   bit_ff, bit_in;
   logic [POP_W-1:0]      count_ff, count_in;
   logic [POP_W-1:0]      rank_ff, rank_in;
   logic [POP_W-1:0]      sel_ff, sel_in;
   logic [THREADS-1:0]    hit_ff, hit_in;
   logic [1:0]            single_kind_ff, single_kind_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [TID_W-1:0]      rsp_thread_ff, rsp_thread_in;
   logic [EVENT_BITS-1:0] rsp_event_ff, rsp_event_in;
   logic                  rsp_last_ff, rsp_last_in;

   store_wr_type          st_wr;
   store_rd_type          st_rd;
   mod_req_type           mod_req;
   mod_rsp_type           mod_rsp;

   logic                  out_free;
   logic                  last_thread;
   logic                  live;
   logic [EVENT_BITS-1:0] allowed;
   logic [THREADS-1:0]    hits_above;
   logic [LFSR_W-1:0]     lfsr_step;
   logic [CNT_W-1:0]      limit_eff;
   logic [LFSR_W-1:0]     seed_eff;

   // done flag of the bidding thread, from a local copy of the table's done flags
   logic                  bid_done;
   logic [THREADS-1:0]    done_vec_ff, done_vec_in;

   eba_bid_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (st_wr),
      .rd_tid (idx_ff),
      .rd     (st_rd)
   );

   eba_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign last_thread = ({1'b0, idx_ff} + CNT_W'(1)) == limit_ff;
   assign live        = !st_rd.done;
   assign allowed     = offer_ff ? (ext_ff & ~blk_or_ff) : (req_or_ff & ~blk_or_ff);
   assign hits_above  = (hit_ff >> idx_ff) >> 1;
   assign lfsr_step   = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   // the active count uses only its low CNT_W bits: 0 acts as 1, above the thread count acts as the maximum
   always_comb begin
      if (csr_data[CNT_W-1:0] == '0) begin
         limit_eff = CNT_W'(1);
      end else if (csr_data[CNT_W-1:0] > MAX_LIMIT) begin
         limit_eff = MAX_LIMIT;
      end else begin
         limit_eff = csr_data[CNT_W-1:0];
      end
      seed_eff = (csr_data == '0) ? LFSR_W'(1) : csr_data;
   end

   always_comb begin
      state_in       = state_ff;
      limit_in       = limit_ff;
      pending_in     = pending_ff;
      lfsr_in        = lfsr_ff;
      awaiting_in    = awaiting_ff;
      offer_in       = offer_ff;
      ext_in         = ext_ff;
      req_or_in      = req_or_ff;
      wait_or_in     = wait_or_ff;
      blk_or_in      = blk_or_ff;
      cand_in        = cand_ff;
      chosen_in      = chosen_ff;
      idx_in         = idx_ff;
      bit_in         = bit_ff;
      count_in       = count_ff;
      rank_in        = rank_ff;
      sel_in         = sel_ff;
      hit_in         = hit_ff;
      single_kind_in = single_kind_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_thread_in = rsp_thread_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_last_in   = rsp_last_ff;

      st_wr              = '0;
      st_wr.bid_tid      = req_thread_id;
      st_wr.bid_req      = req_req_mask;
      st_wr.bid_wait     = req_wait_mask | req_cancel_mask;
      st_wr.bid_block    = req_block_mask;
      st_wr.bid_finished = req_thread_finished;
      st_wr.clr_tid      = idx_ff;
      st_wr.clr_mask     = chosen_ff;

      mod_req          = '0;
      mod_req.dividend = lfsr_step;
      mod_req.divisor  = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in     = '0;
               req_or_in  = '0;
               wait_or_in = '0;
               blk_or_in  = '0;
               ext_in     = req_external_events;
               if (req_opcode == OP_OFFER) begin
                  if (awaiting_ff) begin
                     offer_in = 1'b1;
                     state_in = ST_SCAN;
                  end
               end else if (!awaiting_ff && pending_ff != '0 &&
                            {1'b0, req_thread_id} < limit_ff) begin
                  // bid from a done thread is dropped inside the gate below
                  if (!st_rd.done || idx_ff != req_thread_id) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (live) begin
               req_or_in  = req_or_ff | st_rd.req;
               wait_or_in = wait_or_ff | st_rd.waits;
               blk_or_in  = blk_or_ff | st_rd.block;
            end
            if (last_thread) begin
               idx_in = '0;
               state_in = ST_FIND;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FIND: begin
            if (allowed == '0) begin
               if (offer_ff || wait_or_ff != '0) begin
                  single_kind_in = KIND_EXTERNAL;
                  awaiting_in    = 1'b1;
               end else begin
                  single_kind_in = KIND_FINISHED;
                  awaiting_in    = 1'b0;
               end
               state_in = ST_SINGLE;
            end else if (offer_ff) begin
               // highest unblocked offered bit: rank zero from the top
               cand_in  = allowed;
               sel_in   = '0;
               rank_in  = '0;
               bit_in   = EV_IDX_W'(EVENT_BITS - 1);
               state_in = ST_SELECT;
            end else if (live && (st_rd.req & allowed) != '0) begin
               cand_in  = st_rd.req & allowed;
               count_in = '0;
               bit_in   = '0;
               state_in = ST_COUNT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_COUNT: begin
            count_in = count_ff + POP_W'(cand_ff[bit_ff]);
            if (bit_ff == EV_IDX_W'(EVENT_BITS - 1)) begin
               state_in = ST_DIVIDE;
            end else begin
               bit_in = bit_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (count_ff != '0) begin
               mod_req.start = 1'b1;
               lfsr_in       = lfsr_step;
               count_in      = '0;
            end else if (mod_rsp.done) begin
               sel_in   = mod_rsp.remainder;
               rank_in  = '0;
               bit_in   = EV_IDX_W'(EVENT_BITS - 1);
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (cand_ff[bit_ff]) begin
               if (rank_ff == sel_ff) begin
                  chosen_in = EVENT_BITS'(1) << bit_ff;
                  idx_in    = '0;
                  hit_in    = '0;
                  state_in  = ST_MARK;
               end else begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            bit_in = bit_ff - 1'b1;
         end
         ST_MARK: begin
            hit_in[idx_ff] = live && ((chosen_ff & (st_rd.waits | st_rd.req)) != '0);
            if (last_thread) begin
               idx_in = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (hit_ff == '0) begin
               single_kind_in = KIND_EXTERNAL;
               awaiting_in    = 1'b1;
               state_in       = ST_SINGLE;
            end else if (!hit_ff[idx_ff] || out_free) begin
               if (hit_ff[idx_ff]) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_NOTIFY;
                  rsp_thread_in  = idx_ff;
                  rsp_event_in   = chosen_ff;
                  rsp_last_in    = (hits_above == '0);
                  st_wr.clr_we   = 1'b1;
                  pending_in     = pending_ff + 1'b1;
               end
               if (last_thread) begin
                  awaiting_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = single_kind_ff;
               rsp_thread_in = '0;
               rsp_event_in  = '0;
               rsp_last_in   = 1'b1;
               idx_in        = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a thread bid: store it and count it down, decide when the count hits zero
      if (state_ff == ST_IDLE && req_valid && req_opcode == OP_BID &&
          !awaiting_ff && pending_ff != '0 && {1'b0, req_thread_id} < limit_ff &&
          !bid_done) begin
         st_wr.bid_we = 1'b1;
         pending_in   = pending_ff - 1'b1;
         offer_in     = 1'b0;
         if (pending_ff == CNT_W'(1)) begin
            state_in = ST_SCAN;
         end
      end

      if (csr_valid) begin
         case (csr_index)
            REG_ACTIVE_THREADS: begin
               limit_in   = limit_eff;
               pending_in = limit_eff;
            end
            REG_RANDOM_SEED: begin
               lfsr_in = seed_eff;
            end
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_comb begin
      done_vec_in = done_vec_ff;
      if (st_wr.bid_we && req_thread_finished) begin
         done_vec_in[req_thread_id] = 1'b1;
      end
   end

   assign bid_done = done_vec_ff[req_thread_id];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= MAX_LIMIT;
         pending_ff   <= MAX_LIMIT;
         lfsr_ff      <= LFSR_W'(1);
         awaiting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= '0;
         done_vec_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         pending_ff   <= pending_in;
         lfsr_ff      <= lfsr_in;
         awaiting_ff  <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         done_vec_ff  <= done_vec_in;
      end
      offer_ff       <= offer_in;
      ext_ff         <= ext_in;
      req_or_ff      <= req_or_in;
      wait_or_ff     <= wait_or_in;
      blk_or_ff      <= blk_or_in;
      cand_ff        <= cand_in;
      chosen_ff      <= chosen_in;
      bit_ff         <= bit_in;
      rank_ff        <= rank_in;
      sel_ff         <= sel_in;
      hit_ff         <= hit_in;
      single_kind_ff <= single_kind_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_thread_ff  <= rsp_thread_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_notify_thread = rsp_thread_ff;
   assign rsp_chosen_event  = rsp_event_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
